// ===== src/bpe_pkg.sv =====
// ============================================================================
// bpe_pkg
// Types and constants shared by the Bezier point evaluator modules.
// ============================================================================
package bpe_pkg;

    localparam int MaxPoints  = 8;
    localparam int IdxWidth   = 3;
    localparam int CoordWidth = 16;
    localparam int TFracBits  = 16;
    localparam int GuardBits  = 32;
    localparam int AccWidth   = CoordWidth + GuardBits;
    localparam int NumWidth   = 4;
    localparam logic [NumWidth-1:0] NumPointsReset = NumWidth'(4);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic                         cmd;
        logic [IdxWidth-1:0]          point_index;
        logic signed [CoordWidth-1:0] point_x;
        logic signed [CoordWidth-1:0] point_y;
        logic [TFracBits:0]           param_t;
    } in_item_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] curve_x;
        logic signed [CoordWidth-1:0] curve_y;
    } out_item_t;

    typedef logic signed [AccWidth-1:0] acc_t;

    // one de Casteljau level slot: x and y values
    typedef struct packed {
        acc_t x;
        acc_t y;
    } pt_t;

endpackage

// ===== src/bpe_level.sv =====
// ============================================================================
// bpe_level
// One de Casteljau level: lerps neighbor points, floor toward minus infinity.
// ============================================================================
module bpe_level (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [bpe_pkg::TFracBits:0]  t_in,
    input  logic [bpe_pkg::NumWidth-1:0] n_in,
    input  logic [3:0]                   lvl_in,
    input  bpe_pkg::pt_t                 pts_in [bpe_pkg::MaxPoints],
    output logic                         valid_out,
    output logic [bpe_pkg::TFracBits:0]  t_out,
    output logic [bpe_pkg::NumWidth-1:0] n_out,
    output logic [3:0]                   lvl_out,
    output bpe_pkg::pt_t                 pts_out [bpe_pkg::MaxPoints]
);
    import bpe_pkg::*;

    localparam int ProdWidth = AccWidth + TFracBits + 2;

    logic                valid_reg;
    logic [TFracBits:0]  t_reg;
    logic [NumWidth-1:0] n_reg;
    logic [3:0]          lvl_reg;
    pt_t                 pts_reg [MaxPoints];
    pt_t                 pts_next [MaxPoints];

    // weight of the second point; w_a is the weight of the first
    logic signed [TFracBits+1:0] w_b;
    logic signed [TFracBits+1:0] w_a;
    assign w_b = signed'({1'b0, t_in});
    assign w_a = signed'((TFracBits+2)'(1) <<< TFracBits) - w_b;

    function automatic acc_t lerp(acc_t a, acc_t b,
                                  logic signed [TFracBits+1:0] wa,
                                  logic signed [TFracBits+1:0] wb);
        logic signed [ProdWidth-1:0] s;
        s = ProdWidth'(a) * ProdWidth'(wa) + ProdWidth'(b) * ProdWidth'(wb);
        return s[TFracBits +: AccWidth];
    endfunction

    // lerp active pairs, pass others through
    always_comb
    begin
        for (int i = 0; i < MaxPoints; i++)
        begin
            if (i < MaxPoints - 1 && 32'(lvl_in) < 32'(n_in) && i + 32'(lvl_in) < 32'(n_in))
            begin
                pts_next[i].x = lerp(pts_in[i].x, pts_in[(i+1)%MaxPoints].x, w_a, w_b);
                pts_next[i].y = lerp(pts_in[i].y, pts_in[(i+1)%MaxPoints].y, w_a, w_b);
            end
            else
            begin
                pts_next[i] = pts_in[i];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_in;
            n_reg   <= n_in;
            lvl_reg <= lvl_in + 4'd1;
            pts_reg <= pts_next;
        end
    end

    assign valid_out = valid_reg;
    assign t_out     = t_reg;
    assign n_out     = n_reg;
    assign lvl_out   = lvl_reg;
    assign pts_out   = pts_reg;

endmodule

// ===== src/bezier_point_evaluator.sv =====
// ============================================================================
// bezier_point_evaluator
// Bezier curve point from up to eight Q8.8 control points, de Casteljau pipe.
// ============================================================================
//  channel   direction  handshake        payload
//  in        input      in_valid/ready   in_item_t (load or evaluate)
//  out       output     out_valid/ready  out_item_t (curve point)
//  cfg       input      cfg_we           num_points
//
//  one item enters per cycle while the output is not stalled; an evaluate
//  result passes the entry stage, seven lerp levels and the round stage.
//  a stalled output freezes the whole pipe; nothing is lost or repeated.
//  reset clears valid bits and num_points to 4; point slots start undefined.
module bezier_point_evaluator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bpe_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bpe_pkg::out_item_t             out_item,
    input  logic                           cfg_we,
    input  logic [bpe_pkg::NumWidth-1:0]   cfg_data
);
    import bpe_pkg::*;

    localparam int Levels = MaxPoints - 1;

    logic                 en;
    logic [NumWidth-1:0]  num_points_reg;
    logic [CoordWidth-1:0] ctrl_x_store [MaxPoints];
    logic [CoordWidth-1:0] ctrl_y_store [MaxPoints];

    logic                v_s [Levels+1];
    logic [TFracBits:0]  t_s [Levels+1];
    logic [NumWidth-1:0] n_s [Levels+1];
    logic [3:0]          l_s [Levels+1];
    pt_t                 p_s [Levels+1][MaxPoints];

    logic                valid_reg;
    out_item_t           out_reg;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NumPointsReset;
        end
        else if (cfg_we)
        begin
            num_points_reg <= cfg_data;
        end
    end

    // point store write
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_item.cmd == CMD_LOAD)
        begin
            ctrl_x_store[in_item.point_index] <= in_item.point_x;
            ctrl_y_store[in_item.point_index] <= in_item.point_y;
        end
    end

    // entry stage: read points, clamp t and n
    logic                v0_reg;
    logic [TFracBits:0]  t0_reg;
    logic [NumWidth-1:0] n0_reg;
    pt_t                 p0_reg [MaxPoints];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid && in_item.cmd == CMD_EVAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg <= in_item.param_t[TFracBits] ? (TFracBits+1)'(1) << TFracBits
                                                  : in_item.param_t;
            if (num_points_reg == '0)
                n0_reg <= NumWidth'(1);
            else if (32'(num_points_reg) > MaxPoints)
                n0_reg <= NumWidth'(MaxPoints);
            else
                n0_reg <= num_points_reg;
            for (int i = 0; i < MaxPoints; i++)
            begin
                p0_reg[i].x <= {signed'(ctrl_x_store[i]), {GuardBits{1'b0}}};
                p0_reg[i].y <= {signed'(ctrl_y_store[i]), {GuardBits{1'b0}}};
            end
        end
    end

    assign v_s[0] = v0_reg;
    assign t_s[0] = t0_reg;
    assign n_s[0] = n0_reg;
    assign l_s[0] = 4'd1;
    assign p_s[0] = p0_reg;

    // lerp levels
    for (genvar g = 0; g < Levels; g++)
    begin : g_lvl
        bpe_level u_lvl (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(v_s[g]), .t_in(t_s[g]), .n_in(n_s[g]), .lvl_in(l_s[g]),
            .pts_in(p_s[g]),
            .valid_out(v_s[g+1]), .t_out(t_s[g+1]), .n_out(n_s[g+1]),
            .lvl_out(l_s[g+1]), .pts_out(p_s[g+1])
        );
    end

    // round to nearest and saturate
    function automatic logic [CoordWidth-1:0] finish(acc_t v);
        logic signed [AccWidth:0]          r;
        logic signed [AccWidth-GuardBits:0] q;
        r = {v[AccWidth-1], v} + ((AccWidth+1)'(1) <<< (GuardBits - 1));
        q = r[AccWidth:GuardBits];
        if (q > signed'((AccWidth-GuardBits+1)'((1 << (CoordWidth-1)) - 1)))
            return {1'b0, {(CoordWidth-1){1'b1}}};
        else if (q < -signed'((AccWidth-GuardBits+1)'(1 << (CoordWidth-1))))
            return {1'b1, {(CoordWidth-1){1'b0}}};
        else
            return q[CoordWidth-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= v_s[Levels];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.curve_x <= finish(p_s[Levels][0].x);
            out_reg.curve_y <= finish(p_s[Levels][0].y);
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = out_reg;

endmodule
